@@ hw/rtl/html_text_extractor_core_defines.svh @@
// Assertion macros shared by the html text extractor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HTML_TEXT_EXTRACTOR_CORE_DEFINES_SVH
`define HTML_TEXT_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define HTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define HTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/hte_pkg.sv @@
// Shared types, character codes and tag pattern tables for the html text extractor.
// Depends on nothing; imported by every module of the block.
package hte_pkg;

   localparam int unsigned HIST_DEPTH  = 8;
   localparam int unsigned NUM_PAT     = 4;
   localparam int unsigned FIFO_DEPTH  = 4;
   localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_LT  = 8'h3c;
   localparam logic [7:0] CH_GT  = 8'h3e;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Pattern indexes
   localparam int unsigned PAT_SCRIPT_OPEN  = 0;
   localparam int unsigned PAT_STYLE_OPEN   = 1;
   localparam int unsigned PAT_SCRIPT_CLOSE = 2;
   localparam int unsigned PAT_STYLE_CLOSE  = 3;

   // Byte expected against the current (folded) byte for each pattern
   localparam logic [7:0] PAT_TAIL [NUM_PAT] = '{"t", "e", ">", ">"};

   // Number of history entries each pattern checks
   localparam int unsigned PAT_HIST_LEN [NUM_PAT] = '{6, 5, 8, 7};

   // Expected history, entry 0 is the most recent byte
   localparam logic [7:0] PAT_HIST [NUM_PAT][HIST_DEPTH] = '{
      '{"p", "i", "r", "c", "s", "<", 8'h00, 8'h00},
      '{"l", "y", "t", "s", "<", 8'h00, 8'h00, 8'h00},
      '{"t", "p", "i", "r", "c", "s", "/", "<"},
      '{"e", "l", "y", "t", "s", "/", "<", 8'h00}
   };

   // Compare setup of one history cell
   typedef struct packed {
      logic [NUM_PAT-1:0]      used;
      logic [NUM_PAT-1:0][7:0] chr;
   } cell_expect_type;

   // One result item
   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } result_type;

   // Results produced by one accepted byte
   typedef struct packed {
      logic [1:0] count;
      result_type ent0;
      result_type ent1;
   } push_type;

   // Compare setup for the cell at history position pos
   function automatic cell_expect_type cell_expect(int unsigned pos);
      cell_expect_type e;
      e = '0;
      for (int unsigned p = 0; p < NUM_PAT; p++) begin
         e.used[p] = (pos < PAT_HIST_LEN[p]);
         e.chr[p]  = PAT_HIST[p][pos];
      end
      return e;
   endfunction

endpackage

@@ hw/rtl/html_text_extractor_core.sv @@
// Top level of the html text extractor: text state, history cell chain, result queue.
// Depends on hte_pkg, hte_hist_cell, hte_out_fifo and the assertion macro header.
//
// Usage:
//   req_* carries the document one byte per transfer, req_tlast on the final byte.
//   rsp_* carries the extracted text; rsp_tlast marks the newline that closes
//   a document (or, in raw mode, the final byte passed through).
//   csr_* writes raw_passthrough; write it only while no results are pending.
// A result enters the result queue when its byte is accepted and leaves it on rsp.
// Throughput: one byte per cycle while req_tready is high. A byte yields zero,
//   one or two results; the result queue drains one per cycle, and req_tready
//   stays high while the four-entry queue has room for two more results.
// Reset clears the mode, the byte history, the tag and script flags and the
//   queue. When the receiver stalls, queued results hold and req_tready falls
//   once the queue cannot take a worst-case byte.
// The history is a chain of eight cells; each compares its byte with the
//   tag patterns so the match is one AND over the chain.
`include "html_text_extractor_core_defines.svh"
module html_text_extractor_core
   import hte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_end
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic                raw_ff, raw_in;
   logic                tag_ff, tag_in;
   logic                script_ff, script_in;
   logic                space_ff, space_in;
   logic                accept;
   logic                room_ok;
   logic [7:0]          fold;
   logic [7:0]          hist_q [HIST_DEPTH];
   logic [NUM_PAT-1:0]  cell_hit [HIST_DEPTH];
   logic [NUM_PAT-1:0]  hist_hit;
   logic                open_hit;
   logic                close_hit;
   logic                emit_valid;
   logic [7:0]          emit_data;
   push_type            push;
   result_type          rsp_ent;

   assign csr_ready  = 1'b1;
   assign req_tready = room_ok;
   assign accept     = req_tvalid && req_tready;

   // Fold upper case to lower case
   always_comb begin
      fold = req_tdata;
      if (req_tdata inside {["A":"Z"]}) begin
         fold = req_tdata + CASE_OFFSET;
      end
   end

   // History chain; the newest byte enters cell zero
   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      logic [7:0] cell_d;
      if (k == 0) begin : g_head
         assign cell_d = fold;
      end else begin : g_body
         assign cell_d = hist_q[k-1];
      end
      hte_hist_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept && !raw_ff),
         .clear      (accept && req_tlast),
         .hist_d     (cell_d),
         .expect_cfg (cell_expect(k)),
         .hist_q     (hist_q[k]),
         .hit        (cell_hit[k])
      );
   end

   // Combine cell matches with the current byte
   always_comb begin
      hist_hit = '1;
      for (int unsigned k = 0; k < HIST_DEPTH; k++) begin
         hist_hit = hist_hit & cell_hit[k];
      end
      open_hit  = (hist_hit[PAT_SCRIPT_OPEN] && (fold == PAT_TAIL[PAT_SCRIPT_OPEN])) ||
                  (hist_hit[PAT_STYLE_OPEN] && (fold == PAT_TAIL[PAT_STYLE_OPEN]));
      close_hit = (hist_hit[PAT_SCRIPT_CLOSE] && (fold == PAT_TAIL[PAT_SCRIPT_CLOSE])) ||
                  (hist_hit[PAT_STYLE_CLOSE] && (fold == PAT_TAIL[PAT_STYLE_CLOSE]));
   end

   // Text rules for one byte
   always_comb begin
      raw_in     = raw_ff;
      tag_in     = tag_ff;
      script_in  = script_ff;
      space_in   = space_ff;
      emit_valid = 1'b0;
      emit_data  = req_tdata;
      push       = '0;
      if (csr_valid && csr_ready) begin
         raw_in = csr_data;
      end
      if (accept) begin
         if (raw_ff) begin
            push.count     = 2'd1;
            push.ent0.data = req_tdata;
            push.ent0.last = req_tlast;
         end else begin
            if (open_hit) begin
               script_in = 1'b1;
            end
            if (req_tdata == CH_LT) begin
               tag_in = 1'b1;
            end else if (req_tdata == CH_GT) begin
               tag_in = 1'b0;
               if (!space_ff) begin
                  emit_valid = 1'b1;
                  emit_data  = CH_LF;
                  space_in   = 1'b1;
               end
            end else if (!tag_ff && !script_ff) begin
               if (req_tdata inside {CH_SP, CH_LF, CH_CR, CH_TAB}) begin
                  if (!space_ff) begin
                     emit_valid = 1'b1;
                     emit_data  = CH_SP;
                     space_in   = 1'b1;
                  end
               end else begin
                  emit_valid = 1'b1;
                  space_in   = 1'b0;
               end
            end
            if (close_hit) begin
               script_in = 1'b0;
            end
            // Order the byte result before the closing newline
            push.count     = 2'(emit_valid) + 2'(req_tlast);
            push.ent0.data = emit_valid ? emit_data : CH_LF;
            push.ent0.last = !emit_valid;
            push.ent1.data = CH_LF;
            push.ent1.last = 1'b1;
         end
         if (req_tlast) begin
            tag_in    = 1'b0;
            script_in = 1'b0;
            space_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         tag_ff    <= 1'b0;
         script_ff <= 1'b0;
         space_ff  <= 1'b0;
      end else begin
         raw_ff    <= raw_in;
         tag_ff    <= tag_in;
         script_ff <= script_in;
         space_ff  <= space_in;
      end
   end

   // Result queue between the byte stage and the receiver
   hte_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_ok    (room_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_ent    (rsp_ent)
   );

   assign rsp_tdata = rsp_ent.data;
   assign rsp_tlast = rsp_ent.last;

   `HTE_ASSERT_NEXT(a_last_clears_state, clock, reset, accept && req_tlast, !tag_ff && !script_ff && !space_ff && (hist_q[0] == 8'h00), "text state not cleared after final byte")
   `HTE_ASSERT_NOW(a_text_last_pushes_end, clock, reset, accept && req_tlast && !raw_ff, push.count != 2'd0, "final byte gave no closing result")

endmodule

@@ hw/rtl/hte_hist_cell.sv @@
// One cell of the byte history chain: holds one folded byte, passes it on, compares it.
// Depends on hte_pkg.
module hte_hist_cell
   import hte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic                clear,
   input  logic [7:0]          hist_d,
   input  cell_expect_type     expect_cfg,
   output logic [7:0]          hist_q,
   output logic [NUM_PAT-1:0]  hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Take the neighbor's byte on a shift, drop everything on a clear
   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = '0;
      end else if (shift_en) begin
         byte_in = hist_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign hist_q = byte_ff;

   // Match per pattern; positions a pattern does not reach always match
   always_comb begin
      for (int unsigned p = 0; p < NUM_PAT; p++) begin
         hit[p] = !expect_cfg.used[p] || (byte_ff == expect_cfg.chr[p]);
      end
   end

endmodule

@@ hw/rtl/hte_out_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on hte_pkg and the assertion macro header.
`include "html_text_extractor_core_defines.svh"
module hte_out_fifo
   import hte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room_ok,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_ent
);

   result_type            mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_ent    = mem[rd_ptr_ff];
   assign room_ok    = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the new results in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.ent0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.ent1;
      end
   end

   `HTE_ASSERT_NOW(a_fifo_no_overflow, clock, reset, 1'b1, count_ff <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
   `HTE_ASSERT_NEXT(a_fifo_pop_only, clock, reset, pop && (push.count == 2'd0), count_ff == $past(count_ff) - FIFO_CNT_W'(1), "result queue count lost a transfer")

endmodule

@@ sim/html_text_extractor_core_tb.sv @@
// Self-checking testbench for html_text_extractor_core: drives documents in text and raw
// mode, predicts the extracted text and compares every output transfer in order.
// Depends on hte_pkg and the html_text_extractor_core RTL.
module html_text_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hte_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_LIMIT   = 5000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned SEGMENT_BYTES = 200;
   localparam int unsigned NUM_SEGMENTS  = 6;
   localparam int unsigned MAX_PRINTED   = 30;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } doc_byte_type;

   // Tracks the text state of the block and holds the output bytes still owed
   class text_predictor;
      bit          raw_mode;
      logic [7:0]  history [HIST_DEPTH];
      bit          in_tag;
      bit          script_body;
      bit          space_pending;
      result_type  expected_text [$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         raw_mode   = 1'b0;
         mismatches = 0;
         checked    = 0;
         clear_text();
      endfunction

      function void clear_text();
         foreach (history[i]) history[i] = '0;
         in_tag        = 1'b0;
         script_body   = 1'b0;
         space_pending = 1'b0;
      endfunction

      // True when the history plus the current folded byte ends in pat
      function bit ends_with(string pat, logic [7:0] cur);
         int unsigned n;
         n = pat.len();
         if (8'(pat[n-1]) != cur) return 1'b0;
         for (int unsigned k = 0; k + 1 < n; k++) begin
            if (history[k] != 8'(pat[n-2-k])) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void owe(logic [7:0] d, logic l);
         result_type r;
         r.data = d;
         r.last = l;
         expected_text.push_back(r);
      endfunction

      // Work out the output bytes caused by one accepted document byte
      function void note_byte(logic [7:0] c, logic last);
         logic [7:0] f;
         bit         body_closed;
         if (raw_mode) begin
            owe(c, last);
            if (last) clear_text();
            return;
         end
         f = (c >= "A" && c <= "Z") ? c + CASE_OFFSET : c;
         if (ends_with("<script", f) || ends_with("<style", f)) script_body = 1'b1;
         body_closed = ends_with("</script>", f) || ends_with("</style>", f);
         if (c == CH_LT) begin
            in_tag = 1'b1;
         end else if (c == CH_GT) begin
            in_tag = 1'b0;
            if (!space_pending) begin
               owe(CH_LF, 1'b0);
               space_pending = 1'b1;
            end
         end else if (!in_tag && !script_body) begin
            if (c == CH_SP || c == CH_LF || c == CH_CR || c == CH_TAB) begin
               if (!space_pending) begin
                  owe(CH_SP, 1'b0);
                  space_pending = 1'b1;
               end
            end else begin
               owe(c, 1'b0);
               space_pending = 1'b0;
            end
         end
         // closing tag takes effect from the next byte
         if (body_closed) script_body = 1'b0;
         for (int unsigned k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
         history[0] = f;
         if (last) begin
            owe(CH_LF, 1'b1);
            clear_text();
         end
      endfunction

      task report_mismatch(string msg);
         if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one output transfer with the oldest owed byte
      task check_output(logic [7:0] d, logic l);
         result_type r;
         checked++;
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected output byte %02h end %0b", d, l));
            return;
         end
         r = expected_text.pop_front();
         if (d !== r.data)
            report_mismatch($sformatf("output byte %02h, predicted %02h", d, r.data));
         if (l !== r.last)
            report_mismatch($sformatf("end flag %0b on byte %02h, predicted %0b", l, d, r.last));
      endtask
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;    // [7:0] in_byte
   logic       req_tlast  = 1'b0;  // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic       rsp_tlast;          // out_end
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_data   = 1'b0;

   text_predictor predictor;
   doc_byte_type  doc_q [$];
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   int unsigned   cycle_count   = 0;
   int unsigned   bytes_taken   = 0;
   int unsigned   raw_bytes     = 0;

   html_text_extractor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Stall the receiver at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watch all three channels at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) predictor.raw_mode = csr_data;
         if (req_tvalid && req_tready) begin
            predictor.note_byte(req_tdata, req_tlast);
            bytes_taken++;
            if (predictor.raw_mode) raw_bytes++;
         end
         if (rsp_tvalid && rsp_tready) predictor.check_output(rsp_tdata, rsp_tlast);
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void push_byte(logic [7:0] d, logic l);
      doc_byte_type b;
      b.data = d;
      b.last = l;
      doc_q.push_back(b);
   endfunction

   // Append a string, optionally flipping the case of letters at random
   function automatic void add_text(string s, bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = 8'(s[i]);
         if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
             && $urandom_range(1) == 1)
            c = c ^ CASE_OFFSET;
         push_byte(c, 1'b0);
      end
   endfunction

   function automatic void add_word();
      int unsigned n;
      logic [7:0]  c;
      n = $urandom_range(1, 8);
      repeat (n) begin
         c = 8'($urandom_range(97, 122));
         if ($urandom_range(9) < 3) c = c ^ CASE_OFFSET;
         if ($urandom_range(9) == 0) c = 8'($urandom_range(33, 126));
         push_byte(c, 1'b0);
      end
   endfunction

   function automatic void add_space_run();
      logic [7:0] ws [4];
      ws = '{CH_SP, CH_LF, CH_CR, CH_TAB};
      repeat ($urandom_range(1, 4)) push_byte(ws[$urandom_range(3)], 1'b0);
   endfunction

   function automatic void add_tag();
      string names [10];
      names = '{"p", "div", "a", "span", "b", "br", "scrip", "styl", "scripts", "html"};
      add_text("<", 1'b0);
      if ($urandom_range(2) == 0) add_text("/", 1'b0);
      add_text(names[$urandom_range(9)], 1'b1);
      if ($urandom_range(3) == 0) add_text(" class=x", 1'b1);
      if ($urandom_range(9) != 0) push_byte(CH_GT, 1'b0);
   endfunction

   // Script or style element; most are closed properly, some are broken
   function automatic void add_body_block();
      string kind;
      kind = ($urandom_range(1) == 0) ? "script" : "style";
      add_text({"<", kind}, 1'b1);
      if ($urandom_range(2) == 0) add_text(" type=t", 1'b1);
      push_byte(CH_GT, 1'b0);
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(3))
            0: add_word();
            1: add_space_run();
            2: add_text("a<b", 1'b0);
            default: add_text("x>", 1'b0);
         endcase
      end
      case ($urandom_range(9))
         0: add_text({"</", kind}, 1'b1);
         1: add_text("</scr>", 1'b1);
         2: add_text({"</ ", kind, ">"}, 1'b1);
         default: add_text({"</", kind, ">"}, 1'b1);
      endcase
   endfunction

   function automatic void add_document();
      int unsigned r;
      repeat ($urandom_range(2, 14)) begin
         r = $urandom_range(99);
         if (r < 30) add_word();
         else if (r < 50) add_space_run();
         else if (r < 72) add_tag();
         else if (r < 80) add_body_block();
         else if (r < 88) repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 1'b0);
         else if (r < 94) push_byte(($urandom_range(1) == 0) ? CH_LT : CH_GT, 1'b0);
         else add_text("a&amp;b>c", 1'b0);
      end
      doc_q[doc_q.size()-1].last = 1'b1;
   endfunction

   // Send every queued byte, idling the sender at random between transfers
   task automatic send_doc_bytes();
      int unsigned idx;
      idx = 0;
      while (idx < doc_q.size()) begin
         if ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= doc_q[idx].data;
            req_tlast  <= doc_q[idx].last;
            @(posedge clock);
            while (!(req_tvalid && req_tready)) @(posedge clock);
            idx++;
         end
      end
      req_tvalid <= 1'b0;
      doc_q.delete();
   endtask

   // Hold until every owed byte is out, then let in-flight bytes settle
   task automatic wait_for_drain();
      int unsigned waited;
      waited = 0;
      while (predictor.expected_text.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic raw);
      csr_valid <= 1'b1;
      csr_data  <= raw;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int unsigned seg);
      if (seg < 2) begin
         send_idle_pct = 6;
         recv_idle_pct = 48;
      end else if (seg < 4) begin
         send_idle_pct = 48;
         recv_idle_pct = 6;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      logic mode_plan [NUM_SEGMENTS];
      mode_plan = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      predictor = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(0);

      // Directed text mode: byte extremes, whitespace collapse, tags, style body
      write_mode(1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      add_text("a", 1'b0);
      push_byte(CH_SP, 1'b0);
      push_byte(CH_TAB, 1'b0);
      push_byte(CH_CR, 1'b0);
      push_byte(CH_LF, 1'b0);
      add_text("x<b>>", 1'b0);
      add_text("<sTyle>q</STYLE>", 1'b0);
      push_byte("z", 1'b1);
      send_doc_bytes();
      wait_for_drain();

      // Directed raw mode
      write_mode(1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(CH_LT, 1'b0);
      push_byte(8'hff, 1'b1);
      send_doc_bytes();
      wait_for_drain();

      // Random documents; some segments end mid-document so the mode flips inside one
      for (int unsigned seg = 0; seg < NUM_SEGMENTS; seg++) begin
         set_idling(seg);
         write_mode(mode_plan[seg]);
         while (doc_q.size() < SEGMENT_BYTES) add_document();
         if ($urandom_range(3) == 0) doc_q[doc_q.size()-1].last = 1'b0;
         send_doc_bytes();
         wait_for_drain();
      end

      if (predictor.expected_text.size() != 0)
         predictor.report_mismatch($sformatf("%0d predicted output bytes never arrived",
                                             predictor.expected_text.size()));
      $display("Sent %0d document bytes (%0d in raw mode) under three idling patterns,",
               bytes_taken, raw_bytes);
      $display("compared %0d output bytes, %0d mismatches.", predictor.checked,
               predictor.mismatches);
      if (predictor.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
